// ----- rtl/obbsat_pkg.sv -----
// Shared types, codes and small index tables for the oriented-box
// separating axis test. No dependencies.
package obbsat_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_ROWS        = 10;   // two boxes by five vector kinds

    // vector kinds on the load port
    localparam logic [2:0] MODE_CENTER = 3'd0;
    localparam logic [2:0] MODE_AXIS_X = 3'd1;
    localparam logic [2:0] MODE_HALF   = 3'd4;

    typedef logic [3:0] t_axis;
    typedef logic [1:0] t_comp;
    typedef logic [3:0] t_row;

    localparam t_axis NUM_FACE  = 4'd6;
    localparam t_axis LAST_AXIS = 4'd14;
    localparam t_comp LAST_COMP = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXT_A, S_EXT_M, S_EXT_W,
        S_AXIS, S_LOAD_FACE,
        S_CR_A, S_CR_B, S_CR_C, S_CR_D, S_CR_E,
        S_SQ_M, S_SQ_A, S_SQ_S, S_SQ_W,
        S_PC, S_PT, S_PM, S_PD, S_PU,
        S_CMP, S_MV, S_DV_S, S_DV_W,
        S_NB_S, S_NB_W, S_NB_M,
        S_NEXT, S_FIN
    } t_state;

    function automatic t_row row_addr(input logic box, input logic [2:0] mode);
        return {1'b0, mode} + (box ? 4'd5 : 4'd0);
    endfunction

    function automatic logic [2:0] ax_mode(input t_comp i);
        return MODE_AXIS_X + {1'b0, i};
    endfunction

    function automatic t_comp next_comp(input t_comp c);
        return (c == LAST_COMP) ? 2'd0 : c + 2'd1;
    endfunction

    // face axes: box of the axis
    function automatic logic axis_box(input t_axis k);
        case (k)
            4'd3, 4'd4, 4'd5: return 1'b1;
            default:          return 1'b0;
        endcase
    endfunction

    // axis index within its box of a face axis, or first-box axis of an edge axis
    function automatic t_comp axis_i(input t_axis k);
        case (k)
            4'd0, 4'd3, 4'd6, 4'd7, 4'd8:     return 2'd0;
            4'd1, 4'd4, 4'd9, 4'd10, 4'd11:   return 2'd1;
            4'd2, 4'd5, 4'd12, 4'd13, 4'd14:  return 2'd2;
            default:                          return 2'd0;
        endcase
    endfunction

    // second-box axis of an edge axis
    function automatic t_comp axis_j(input t_axis k);
        case (k)
            4'd7, 4'd10, 4'd13: return 2'd1;
            4'd8, 4'd11, 4'd14: return 2'd2;
            default:            return 2'd0;
        endcase
    endfunction

endpackage

// ----- rtl/obb_obb_separating_axis_test.sv -----
// Oriented box pair overlap test over 15 candidate axes, with a sequencer
// driving the shared multiplier, divider and square root units.
// Depends on obbsat_pkg, obbsat_mul, obbsat_div and obbsat_sqrt.
//
// An evaluate transaction first builds the six scaled box edges (18
// components), then walks the axes one by one: each axis takes the
// projections of the 16 box corners through the one multiplier, the axis
// length through the square root, and one division for the depth (three
// more when the axis becomes the new minimum). A separating axis found
// early ends the run sooner.
// The input stalls for the whole run. A finished result waits in the output
// register while new loads are taken.
module obb_obb_separating_axis_test #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = obbsat_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic               i_box_sel,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic signed [31:0] i_z_value,
    input  logic               i_evaluate,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_overlap,
    output logic signed [31:0] o_move_x,
    output logic signed [31:0] o_move_y,
    output logic signed [31:0] o_move_z,
    output logic [3:0]         o_axis_index
);
    import obbsat_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [31:0]  O_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0]  O_MIN = 32'sh8000_0000;

    typedef logic signed [W-1:0] t_val;

    function automatic t_val sadd(input t_val a, input t_val b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
        return s[W-1:0];
    endfunction

    function automatic t_val sneg(input t_val a);
        return (a == MINV) ? MAXV : t_val'(-a);
    endfunction

    function automatic t_val ld(input logic [31:0] raw);
        logic signed [EW-1:0] e;
        e = EW'($signed(raw));
        if (e > EW'(MAXV)) return MAXV;
        if (e < EW'(MINV)) return MINV;
        return W'(e);
    endfunction

    function automatic logic signed [31:0] out32(input t_val v);
        logic signed [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(O_MAX)) return O_MAX;
        if (e < EW'(O_MIN)) return O_MIN;
        return 32'(e);
    endfunction

    t_state r_state, n_state;

    logic [95:0] r_store [NUM_ROWS];
    t_val  r_ext [2][3][3];
    t_val  r_l [3];
    t_val  r_best_mv [3];
    t_val  r_lo [2];
    t_val  r_hi [2];
    t_val  r_len, r_opa, r_t, r_acc, r_dot, r_m1, r_m2, r_move, r_depth, r_best_depth;
    logic  r_low, r_have, r_sep, r_box;
    t_axis r_axis, r_best_ax;
    t_comp r_comp, r_term, r_ai;
    logic [2:0]       r_corner;
    logic [2*W+1:0]   r_sum;

    logic               r_out_valid, r_overlap;
    logic signed [31:0] r_mx, r_my, r_mz;
    t_axis              r_ax_out;

    // unit hookup
    t_row         rd_row;
    t_comp        rd_comp;
    logic [95:0]  rd_word;
    logic [31:0]  rd_raw;
    t_val         rd_val;
    logic         mul_start, div_start, sq_start;
    t_val         mul_a, mul_b, mul_q, div_a, div_q;
    logic [2*W-1:0] mul_prod;
    logic         div_done, sq_done;
    logic [W:0]   sq_root;
    t_val         ext_e, pv;
    t_comp        cp, cq;
    logic         accept, out_take, fin_load;

    obbsat_mul #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_q(mul_q), .o_prod(mul_prod)
    );

    obbsat_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_a(div_a),
        .i_b(r_len), .o_done(div_done), .o_q(div_q)
    );

    obbsat_sqrt #(.COORD_WIDTH(W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_rad(r_sum),
        .o_done(sq_done), .o_root(sq_root)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_take = r_out_valid && !i_out_stall;
    assign fin_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign cp       = next_comp(r_comp);
    assign cq       = next_comp(cp);
    assign ext_e    = r_ext[r_box][r_term][r_comp];

    always_comb begin
        rd_word = r_store[rd_row];
        case (rd_comp)
            2'd0:    rd_raw = rd_word[31:0];
            2'd1:    rd_raw = rd_word[63:32];
            default: rd_raw = rd_word[95:64];
        endcase
        rd_val = ld(rd_raw);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (accept && i_evaluate) n_state = S_EXT_A;
            S_EXT_A:     n_state = S_EXT_M;
            S_EXT_M:     n_state = S_EXT_W;
            S_EXT_W: begin
                if (r_comp != LAST_COMP)  n_state = S_EXT_M;
                else if (r_ai != LAST_COMP || !r_box) n_state = S_EXT_A;
                else n_state = S_AXIS;
            end
            S_AXIS:      n_state = (r_axis < NUM_FACE) ? S_LOAD_FACE : S_CR_A;
            S_LOAD_FACE: n_state = (r_comp == LAST_COMP) ? S_SQ_M : S_LOAD_FACE;
            S_CR_A:      n_state = S_CR_B;
            S_CR_B:      n_state = S_CR_C;
            S_CR_C:      n_state = S_CR_D;
            S_CR_D:      n_state = S_CR_E;
            S_CR_E:      n_state = (r_comp == LAST_COMP) ? S_SQ_M : S_CR_A;
            S_SQ_M:      n_state = S_SQ_A;
            S_SQ_A:      n_state = (r_comp == LAST_COMP) ? S_SQ_S : S_SQ_M;
            S_SQ_S:      n_state = S_SQ_W;
            S_SQ_W:      if (sq_done) n_state = (sq_root == '0) ? S_NEXT : S_PC;
            S_PC:        n_state = S_PT;
            S_PT:        n_state = (r_term == LAST_COMP) ? S_PM : S_PT;
            S_PM:        n_state = S_PD;
            S_PD:        n_state = (r_comp == LAST_COMP) ? S_PU : S_PC;
            S_PU:        n_state = (r_corner == 3'd7 && r_box) ? S_CMP : S_PC;
            S_CMP:       n_state = (r_lo[1] > r_hi[0] || r_hi[1] < r_lo[0]) ? S_FIN : S_MV;
            S_MV:        n_state = S_DV_S;
            S_DV_S:      n_state = S_DV_W;
            S_DV_W: begin
                if (div_done)
                    n_state = (!r_have || div_q < r_best_depth) ? S_NB_S : S_NEXT;
            end
            S_NB_S:      n_state = S_NB_W;
            S_NB_W:      if (div_done) n_state = S_NB_M;
            S_NB_M:      n_state = (r_comp == LAST_COMP) ? S_NEXT : S_NB_S;
            S_NEXT:      n_state = (r_axis == LAST_AXIS) ? S_FIN : S_AXIS;
            S_FIN:       if (fin_load) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // unit controls and store read port
    always_comb begin
        rd_row    = row_addr(r_box, MODE_CENTER);
        rd_comp   = r_comp;
        mul_start = 1'b0;
        mul_a     = r_opa;
        mul_b     = rd_val;
        div_start = 1'b0;
        div_a     = r_move;
        sq_start  = 1'b0;
        case (r_state)
            S_EXT_A: begin
                rd_row  = row_addr(r_box, MODE_HALF);
                rd_comp = r_ai;
            end
            S_EXT_M: begin
                rd_row    = row_addr(r_box, ax_mode(r_ai));
                mul_start = 1'b1;
            end
            S_LOAD_FACE: rd_row = row_addr(axis_box(r_axis), ax_mode(axis_i(r_axis)));
            S_CR_A: begin
                rd_row  = row_addr(1'b0, ax_mode(axis_i(r_axis)));
                rd_comp = cp;
            end
            S_CR_B: begin
                rd_row    = row_addr(1'b1, ax_mode(axis_j(r_axis)));
                rd_comp   = cq;
                mul_start = 1'b1;
            end
            S_CR_C: begin
                rd_row  = row_addr(1'b0, ax_mode(axis_i(r_axis)));
                rd_comp = cq;
            end
            S_CR_D: begin
                rd_row    = row_addr(1'b1, ax_mode(axis_j(r_axis)));
                rd_comp   = cp;
                mul_start = 1'b1;
            end
            S_SQ_M: begin
                mul_a     = r_l[r_comp];
                mul_b     = r_l[r_comp];
                mul_start = 1'b1;
            end
            S_SQ_S: sq_start = 1'b1;
            S_PM: begin
                mul_a     = r_acc;
                mul_b     = r_l[r_comp];
                mul_start = 1'b1;
            end
            S_DV_S: div_start = 1'b1;
            S_NB_S: begin
                div_a     = r_l[r_comp];
                div_start = 1'b1;
            end
            S_NB_W: begin
                mul_a     = r_depth;
                mul_b     = div_q;
                mul_start = div_done;
            end
            default: ;
        endcase
    end

    assign pv = sadd((r_comp == 2'd0) ? t_val'(0) : r_dot, mul_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept && i_mode <= MODE_HALF)
            r_store[row_addr(i_box_sel, i_mode)] <= {i_z_value, i_y_value, i_x_value};

        case (r_state)
            S_IDLE: begin
                r_box    <= 1'b0;
                r_ai     <= '0;
                r_comp   <= '0;
                r_axis   <= '0;
                r_have   <= 1'b0;
                r_sep    <= 1'b0;
                r_best_ax <= '0;
                for (int c = 0; c < 3; c++) r_best_mv[c] <= '0;
            end
            S_EXT_A: r_opa <= rd_val;
            S_EXT_W: begin
                r_ext[r_box][r_ai][r_comp] <= mul_q;
                r_comp <= next_comp(r_comp);
                if (r_comp == LAST_COMP) begin
                    r_ai <= next_comp(r_ai);
                    if (r_ai == LAST_COMP) r_box <= ~r_box;
                end
            end
            S_AXIS: begin
                r_comp <= '0;
                r_sum  <= '0;
            end
            S_LOAD_FACE: begin
                r_l[r_comp] <= rd_val;
                r_comp      <= next_comp(r_comp);
            end
            S_CR_A: r_opa <= rd_val;
            S_CR_C: begin
                r_t   <= mul_q;
                r_opa <= rd_val;
            end
            S_CR_E: begin
                r_l[r_comp] <= sadd(r_t, sneg(mul_q));
                r_comp      <= next_comp(r_comp);
            end
            S_SQ_A: begin
                r_sum  <= r_sum + (2*W+2)'(mul_prod);
                r_comp <= next_comp(r_comp);
            end
            S_SQ_W: begin
                r_len    <= (sq_root > (W+1)'(MAXV)) ? MAXV : t_val'(sq_root[W-1:0]);
                r_box    <= 1'b0;
                r_corner <= '0;
                r_comp   <= '0;
            end
            S_PC: begin
                r_acc  <= rd_val;
                r_term <= '0;
            end
            S_PT: begin
                r_acc  <= sadd(r_acc, r_corner[r_term] ? ext_e : sneg(ext_e));
                r_term <= next_comp(r_term);
            end
            S_PD: begin
                r_dot  <= pv;
                r_comp <= next_comp(r_comp);
            end
            S_PU: begin
                if (r_corner == 3'd0 || r_dot < r_lo[r_box]) r_lo[r_box] <= r_dot;
                if (r_corner == 3'd0 || r_dot > r_hi[r_box]) r_hi[r_box] <= r_dot;
                r_corner <= r_corner + 3'd1;
                if (r_corner == 3'd7) r_box <= ~r_box;
            end
            S_CMP: begin
                r_sep <= r_lo[1] > r_hi[0] || r_hi[1] < r_lo[0];
                r_m1  <= sadd(r_hi[0], sneg(r_lo[1]));
                r_m2  <= sadd(r_hi[1], sneg(r_lo[0]));
            end
            S_MV: begin
                r_low  <= r_m1 < r_m2;
                r_move <= (r_m1 < r_m2) ? r_m1 : r_m2;
            end
            S_DV_W: begin
                if (div_done) begin
                    r_depth <= div_q;
                    r_comp  <= '0;
                    if (!r_have || div_q < r_best_depth) begin
                        r_have       <= 1'b1;
                        r_best_depth <= div_q;
                        r_best_ax    <= r_axis;
                    end
                end
            end
            S_NB_M: begin
                r_best_mv[r_comp] <= r_low ? sneg(mul_q) : mul_q;
                r_comp            <= next_comp(r_comp);
            end
            S_NEXT: r_axis <= r_axis + 4'd1;
            default: ;
        endcase

        if (fin_load) begin
            r_overlap <= ~r_sep;
            r_mx      <= r_sep ? 32'sd0 : out32(r_best_mv[0]);
            r_my      <= r_sep ? 32'sd0 : out32(r_best_mv[1]);
            r_mz      <= r_sep ? 32'sd0 : out32(r_best_mv[2]);
            r_ax_out  <= r_sep ? r_axis : r_best_ax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_overlap    = r_overlap;
    assign o_move_x     = r_mx;
    assign o_move_y     = r_my;
    assign o_move_z     = r_mz;
    assign o_axis_index = r_ax_out;

endmodule

// ----- rtl/obbsat_mul.sv -----
// Shared fixed-point multiplier: registered magnitude product, with the
// truncated and saturated Q result and the exact magnitude product on the outputs.
module obbsat_mul #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = obbsat_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    output logic signed [COORD_WIDTH-1:0] o_q,
    output logic [2*COORD_WIDTH-1:0]      o_prod
);
    localparam int W = COORD_WIDTH;
    localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};

    logic [2*W-1:0] r_mag;
    logic           r_neg;
    logic [2*W-1:0] shifted;
    logic [2*W-1:0] lim;
    logic [W-1:0]   mag;

    function automatic logic [W-1:0] magn(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= (2*W)'(magn(i_a)) * (2*W)'(magn(i_b));
            r_neg <= i_a[W-1] ^ i_b[W-1];
        end
    end

    always_comb begin
        shifted = r_mag >> FRAC_BITS;
        lim     = r_neg ? LIM_POS + 1'b1 : LIM_POS;
        mag     = (shifted > lim) ? W'(lim) : W'(shifted);
        o_q     = r_neg ? W'(-mag) : W'(mag);
        o_prod  = r_mag;
    end

endmodule

// ----- rtl/obbsat_div.sv -----
// Restoring bit-serial fixed-point divider, one quotient bit per cycle,
// saturated signed Q result. Depends on obbsat_pkg for defaults.
module obbsat_div #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = obbsat_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_q
);
    localparam int W  = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW);
    localparam logic [NW-1:0] LIM_POS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_rem;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    trial;
    logic          fits;
    logic [NW-1:0] lim;
    logic [W-1:0]  mag;

    function automatic logic [W-1:0] magn(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    assign trial = {r_rem, r_num[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= NW'(magn(i_a)) << FRAC_BITS;
                r_den  <= magn(i_b);
                r_rem  <= '0;
                r_quot <= '0;
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? W'(trial - {1'b0, r_den}) : W'(trial);
                r_quot <= {r_quot[NW-2:0], fits};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        lim    = r_neg ? LIM_POS + 1'b1 : LIM_POS;
        mag    = (r_quot > lim) ? W'(lim) : W'(r_quot);
        o_q    = r_neg ? W'(-mag) : W'(mag);
        o_done = r_done;
    end

endmodule

// ----- rtl/obbsat_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on obbsat_pkg for defaults.
module obbsat_sqrt #(
    parameter int COORD_WIDTH = obbsat_pkg::COORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*COORD_WIDTH+1:0]  i_rad,
    output logic                      o_done,
    output logic [COORD_WIDTH:0]      o_root
);
    localparam int W  = COORD_WIDTH;
    localparam int RW = 2*COORD_WIDTH + 2;
    localparam int N  = COORD_WIDTH + 1;
    localparam int CW = $clog2(N);

    logic [RW-1:0]  r_rad;
    logic [W+3:0]   r_rem;
    logic [W:0]     r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [W+3:0]   rem2;
    logic [W+3:0]   trial;
    logic           fits;

    assign rem2  = {r_rem[W+1:0], r_rad[RW-1:RW-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? rem2 - trial : rem2;
                r_root <= {r_root[W-1:0], fits};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(N-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- sim/tb.sv -----
// Testbench for obb_obb_separating_axis_test: self-checking, with a built-in
// fixed-point predictor of the 15-axis box test. Depends on rtl/obbsat_pkg.sv.
`timescale 1ns / 100ps

module tb;
    import obbsat_pkg::*;

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -MAXV - 1;
    localparam logic [2:0] MODE_AXIS_Y = 3'd2;
    localparam logic [2:0] MODE_AXIS_Z = 3'd3;
    localparam logic signed [31:0] ONE = 32'sd65536;

    typedef longint t_vec3 [3];

    typedef struct {
        logic              overlap;
        logic signed [31:0] mx, my, mz;
        logic [3:0]        axis;
    } t_contact;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_mode = '0;
    logic               i_box_sel = 1'b0;
    logic signed [31:0] i_x_value = '0;
    logic signed [31:0] i_y_value = '0;
    logic signed [31:0] i_z_value = '0;
    logic               i_evaluate = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_overlap;
    logic signed [31:0] o_move_x, o_move_y, o_move_z;
    logic [3:0]         o_axis_index;

    obb_obb_separating_axis_test dut (.*);

    always #5 i_clk = ~i_clk;

    logic signed [31:0] box_mem [2][5][3];
    t_contact contact_q [$];
    int n_items = 0;
    int n_evals = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_separated = 0;
    bit quiet = 1'b0;

    // ---------------- fixed-point predictor ----------------
    function automatic longint unsigned mag(longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    function automatic longint clamp_mag(bit neg, longint unsigned m);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat(longint x);
        return x > MAXV ? MAXV : (x < MINV ? MINV : x);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return sat(a + b);
    endfunction

    function automatic longint qneg(longint a);
        return a == MINV ? MAXV : -a;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> 16);
    endfunction

    function automatic longint qdiv(longint a, longint b);
        return clamp_mag((a < 0) != (b < 0), (mag(a) << 16) / mag(b));
    endfunction

    function automatic longint vec_len(t_vec3 v);
        logic [127:0] s, c;
        longint unsigned root;
        s = 0;
        root = 0;
        for (int i = 0; i < 3; i++) s += 128'(mag(v[i])) * 128'(mag(v[i]));
        for (int b = 63; b >= 0; b--) begin
            c = 128'(root | (64'd1 << b));
            if (c * c <= s) root = c[63:0];
        end
        return clamp_mag(1'b0, root);
    endfunction

    function automatic longint rd(int box, int mode, int c);
        return longint'(box_mem[box][mode][c]);
    endfunction

    function automatic longint dot(t_vec3 a, t_vec3 b);
        return qadd(qadd(qmul(a[0], b[0]), qmul(a[1], b[1])), qmul(a[2], b[2]));
    endfunction

    task automatic project(input int box, input t_vec3 L, output longint lo, output longint hi);
        longint ext [3][3];
        t_vec3 cen, p;
        longint v;
        for (int c = 0; c < 3; c++) begin
            cen[c] = rd(box, 0, c);
            for (int i = 0; i < 3; i++) ext[i][c] = qmul(rd(box, 4, i), rd(box, 1 + i, c));
        end
        for (int j = 0; j < 8; j++) begin
            for (int c = 0; c < 3; c++) begin
                p[c] = cen[c];
                for (int i = 0; i < 3; i++)
                    p[c] = qadd(p[c], ((j >> i) & 1) ? ext[i][c] : qneg(ext[i][c]));
            end
            v = dot(p, L);
            if (j == 0 || v < lo) lo = v;
            if (j == 0 || v > hi) hi = v;
        end
    endtask

    task automatic predict_contact(output t_contact r);
        t_vec3 L, a, b, best_mv;
        longint len, lo1, hi1, lo2, hi2, m1, m2, move, depth, best_depth, t;
        int best_ax;
        bit have, low;
        best_mv = '{0, 0, 0};
        best_depth = 0;
        best_ax = 0;
        have = 0;
        for (int k = 0; k < 15; k++) begin
            if (k < 6) begin
                for (int c = 0; c < 3; c++) L[c] = rd(k / 3, 1 + k % 3, c);
            end else begin
                for (int c = 0; c < 3; c++) begin
                    a[c] = rd(0, 1 + (k - 6) / 3, c);
                    b[c] = rd(1, 1 + (k - 6) % 3, c);
                end
                L[0] = qadd(qmul(a[1], b[2]), qneg(qmul(a[2], b[1])));
                L[1] = qadd(qmul(a[2], b[0]), qneg(qmul(a[0], b[2])));
                L[2] = qadd(qmul(a[0], b[1]), qneg(qmul(a[1], b[0])));
            end
            len = vec_len(L);
            if (len == 0) continue;
            project(0, L, lo1, hi1);
            project(1, L, lo2, hi2);
            if (lo2 > hi1 || hi2 < lo1) begin
                r = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 4'(k)};
                return;
            end
            m1 = qadd(hi1, qneg(lo2));
            m2 = qadd(hi2, qneg(lo1));
            low = m1 < m2;
            move = low ? m1 : m2;
            depth = qdiv(move, len);
            if (!have || depth < best_depth) begin
                have = 1;
                best_depth = depth;
                best_ax = k;
                for (int c = 0; c < 3; c++) begin
                    t = qmul(depth, qdiv(L[c], len));
                    best_mv[c] = low ? qneg(t) : t;
                end
            end
        end
        r = '{1'b1, 32'(best_mv[0]), 32'(best_mv[1]), 32'(best_mv[2]), 4'(best_ax)};
    endtask

    // ---------------- driving ----------------
    task automatic send_vec(input logic [2:0] m, input logic b, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic signed [31:0] z,
                            input logic ev);
        t_contact r;
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_box_sel  <= b;
        i_x_value  <= x;
        i_y_value  <= y;
        i_z_value  <= z;
        i_evaluate <= ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (m <= MODE_HALF) begin
            box_mem[b][m][0] = x;
            box_mem[b][m][1] = y;
            box_mem[b][m][2] = z;
        end
        if (ev) begin
            predict_contact(r);
            contact_q.push_back(r);
            n_evals++;
            if (!r.overlap) n_separated++;
        end
        n_items++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic load_box(input logic b, input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic signed [31:0] cz, input logic signed [31:0] h,
                            input logic ev);
        send_vec(MODE_CENTER, b, cx, cy, cz, 1'b0);
        send_vec(MODE_AXIS_X, b, ONE, 0, 0, 1'b0);
        send_vec(MODE_AXIS_Y, b, 0, ONE, 0, 1'b0);
        send_vec(MODE_AXIS_Z, b, 0, 0, ONE, 1'b0);
        send_vec(MODE_HALF, b, h, h, h, ev);
    endtask

    // output side: random stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_contact e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (contact_q.size() == 0) begin
                $error("result with no pending transaction");
                n_errors++;
            end else begin
                e = contact_q.pop_front();
                n_checked++;
                if (o_overlap !== e.overlap) begin
                    $error("overlap: expected %0d, got %0d", e.overlap, o_overlap);
                    n_errors++;
                end
                if (o_move_x !== e.mx) begin
                    $error("move_x: expected %0d, got %0d", e.mx, o_move_x);
                    n_errors++;
                end
                if (o_move_y !== e.my) begin
                    $error("move_y: expected %0d, got %0d", e.my, o_move_y);
                    n_errors++;
                end
                if (o_move_z !== e.mz) begin
                    $error("move_z: expected %0d, got %0d", e.mz, o_move_z);
                    n_errors++;
                end
                if (o_axis_index !== e.axis) begin
                    $error("axis_index: expected %0d, got %0d", e.axis, o_axis_index);
                    n_errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_aligned_boxes();
        load_box(1'b0, 0, 0, 0, ONE, 1'b0);
        load_box(1'b1, ONE, ONE / 2, 0, ONE, 1'b1);
    endtask

    task automatic test_separation_and_contact();
        send_vec(MODE_CENTER, 1'b1, 5 * ONE, 0, 0, 1'b1);    // clearly apart
        send_vec(MODE_CENTER, 1'b1, 2 * ONE, 0, 0, 1'b1);    // faces just touch
        send_vec(MODE_CENTER, 1'b1, 0, 0, 0, 1'b1);          // identical boxes, tied depths
    endtask

    task automatic test_rotated_and_zero_axes();
        send_vec(MODE_AXIS_X, 1'b1, 46341, 46341, 0, 1'b0);
        send_vec(MODE_AXIS_Y, 1'b1, -46341, 46341, 0, 1'b1);
        send_vec(MODE_AXIS_X, 1'b0, 0, 0, 0, 1'b0);
        send_vec(MODE_AXIS_Y, 1'b0, 0, 0, 0, 1'b0);
        send_vec(MODE_AXIS_Z, 1'b0, 0, 0, 0, 1'b0);
        send_vec(MODE_AXIS_X, 1'b1, 0, 0, 0, 1'b0);
        send_vec(MODE_AXIS_Y, 1'b1, 0, 0, 0, 1'b0);
        send_vec(MODE_AXIS_Z, 1'b1, 0, 0, 0, 1'b1);          // nothing to test
    endtask

    task automatic test_unknown_modes();
        send_vec(3'd5, 1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_vec(3'd6, 1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
        send_vec(3'd7, 1'b1, -1, -1, -1, 1'b1);
    endtask

    task automatic test_extremes();
        send_vec(MODE_AXIS_X, 1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
        send_vec(MODE_HALF, 1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0);
        send_vec(MODE_CENTER, 1'b1, 32'sh80000000, 32'sh7fffffff, -1, 1'b1);
    endtask

    function automatic logic signed [31:0] rand_comp(logic [2:0] m);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom;
        case (m)
            MODE_CENTER: return $signed($urandom_range(0, 6 * ONE)) - 3 * ONE;
            MODE_HALF:   return $urandom_range(0, 3 * ONE);
            default: begin
                if (r < 5) return 0;
                if (r < 8) return $urandom_range(0, 1) ? ONE : -ONE;
                return $signed($urandom_range(0, 2 * ONE)) - ONE;
            end
        endcase
    endfunction

    task automatic test_random_traffic();
        logic [2:0] m;
        logic b;
        int r;
        while (n_items < 1725 || n_evals < 45) begin
            if (n_items > 1550) quiet = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                b = $urandom_range(0, 1);
                for (int k = 0; k <= MODE_HALF; k++)
                    send_vec(3'(k), b, rand_comp(3'(k)), rand_comp(3'(k)), rand_comp(3'(k)),
                             k == MODE_HALF && $urandom_range(0, 4) == 0);
            end else begin
                r = $urandom_range(0, 19);
                m = r < 18 ? 3'(r % 5) : 3'($urandom_range(5, 7));
                send_vec(m, $urandom_range(0, 1), rand_comp(m), rand_comp(m), rand_comp(m),
                         $urandom_range(0, 39) == 0);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_aligned_boxes();
        test_separation_and_contact();
        test_rotated_and_zero_axes();
        test_unknown_modes();
        test_extremes();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d vector transactions, %0d evaluations (%0d separated).",
                 n_items, n_evals, n_separated);
        $display("Checked %0d results, %0d field errors.", n_checked, n_errors);
        if (n_errors == 0 && contact_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("Timeout with %0d results pending", contact_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
